// ----- sv/pmp_pkg.sv -----
// Shared types, codes and constants for the physical memory protection region checker.
package pmp_pkg;

    // Field widths of the item and of a stored entry.
    localparam int BASE_W = 56;
    localparam int SIZE_W = 58;
    localparam int ADDR_W = 54;
    localparam int END_W  = SIZE_W + 1;
    localparam int REG_W  = BASE_W + 1;

    // Default table shape.
    localparam int DEF_NUM_HARTS   = 4;
    localparam int DEF_NUM_ENTRIES = 16;

    // Configuration byte layout.
    localparam int MODE_LSB = 3;
    localparam int MODE_MSB = 4;

    // Matching modes.
    localparam logic [1:0] MODE_OFF   = 2'd0;
    localparam logic [1:0] MODE_TOR   = 2'd1;
    localparam logic [1:0] MODE_NA4   = 2'd2;
    localparam logic [1:0] MODE_NAPOT = 2'd3;

    // Opcodes.
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Result selection codes.
    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_MISS = 2'd1;
    localparam logic [1:0] RES_HIT  = 2'd2;

    // Size of a four-byte entry.
    localparam logic [SIZE_W-1:0] NA4_SIZE = SIZE_W'(4);

    // One stored entry apart from its mode.
    typedef struct packed {
        logic [1:0]        read_write;
        logic [SIZE_W-1:0] size;
        logic [BASE_W-1:0] base;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       rd_prev;
        logic       sum_base;
        logic       write_entry;
        logic       walk;
        logic       set_result;
        logic [1:0] result_sel;
        logic       emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] opcode;
        logic       hart_ok;
        logic       load_ok;
        logic       tor_prev;
        logic       hit;
        logic       walk_end;
        logic       out_free;
    } t_dp_status;

endpackage

// ----- sv/pmp_ctrl.sv -----
// Controller state machine that sequences loads and entry walks.
module pmp_ctrl
    import pmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_LD_READ  = 3'd2;
    localparam logic [2:0] S_LD_SUM   = 3'd3;
    localparam logic [2:0] S_LD_WRITE = 3'd4;
    localparam logic [2:0] S_WALK     = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.opcode)
                    OP_LOAD: begin
                        if (!i_status.load_ok) begin
                            o_cmd.set_result = 1'b1;
                            o_cmd.result_sel = RES_ZERO;
                            n_state          = S_FINISH;
                        end else if (i_status.tor_prev) begin
                            n_state = S_LD_READ;
                        end else begin
                            n_state = S_LD_WRITE;
                        end
                    end
                    OP_READ, OP_WRITE: begin
                        if (!i_status.hart_ok) begin
                            o_cmd.set_result = 1'b1;
                            o_cmd.result_sel = RES_MISS;
                            n_state          = S_FINISH;
                        end else begin
                            n_state = S_WALK;
                        end
                    end
                    default: begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.result_sel = RES_ZERO;
                        n_state          = S_FINISH;
                    end
                endcase
            end
            S_LD_READ: begin
                o_cmd.rd_prev = 1'b1;
                n_state       = S_LD_SUM;
            end
            S_LD_SUM: begin
                o_cmd.sum_base = 1'b1;
                n_state        = S_LD_WRITE;
            end
            S_LD_WRITE: begin
                o_cmd.write_entry = 1'b1;
                o_cmd.set_result  = 1'b1;
                o_cmd.result_sel  = RES_ZERO;
                n_state           = S_FINISH;
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.hit) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result_sel = RES_HIT;
                    n_state          = S_FINISH;
                end else if (i_status.walk_end) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.result_sel = RES_MISS;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/pmp_datapath.sv -----
// Datapath: item registers, entry memories, decode and containment logic, result register.
module pmp_datapath
    import pmp_pkg::*;
#(
    parameter int NUM_HARTS   = DEF_NUM_HARTS,
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [1:0]        i_opcode,
    input  logic [1:0]        i_hart,
    input  logic [3:0]        i_entry_index,
    input  logic [7:0]        i_cfg_byte,
    input  logic [ADDR_W-1:0] i_addr_word,
    input  logic [BASE_W-1:0] i_region_start,
    input  logic [BASE_W-1:0] i_region_length,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic              o_allowed
);

    localparam int SLOTS  = NUM_HARTS * NUM_ENTRIES;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // Latched item fields.
    logic [1:0]        r_opcode;
    logic [1:0]        r_hart;
    logic [3:0]        r_entry_index;
    logic [7:0]        r_cfg_byte;
    logic [ADDR_W-1:0] r_addr_word;
    logic [BASE_W-1:0] r_region_start;
    logic [REG_W-1:0]  r_region_end;

    // Working registers.
    logic [BASE_W-1:0] r_base;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_issued_all;
    logic              r_live;
    logic              r_result;
    logic              r_out_valid;
    logic              r_allowed;

    // Entry storage and its registered read port.
    logic [1:0]        mode_mem [SLOTS];
    t_entry            data_mem [SLOTS];
    logic [SLOTS-1:0]  r_slot_valid;
    logic [1:0]        r_rd_mode;
    t_entry            r_rd_data;
    logic              r_rd_valid;

    logic [31:0]       walk_full;
    logic [31:0]       load_full;
    logic [SLOT_W-1:0] walk_slot;
    logic [SLOT_W-1:0] load_slot;
    logic [SLOT_W-1:0] prev_slot;
    logic [SLOT_W-1:0] rd_addr;
    logic              issue;
    logic [1:0]        ld_mode;
    logic [1:0]        prev_mode;
    t_entry            prev_entry;
    logic [END_W-1:0]  prev_end;
    logic [BASE_W-1:0] top;
    logic [REG_W-1:0]  tor_diff;
    logic [ADDR_W-1:0] word_inc;
    logic [ADDR_W-1:0] low_zero;
    t_entry            wr_entry;
    logic              data_we;
    logic              match;
    logic              hit_bit;

    // Slot addresses.
    assign walk_full = 32'(r_hart) * 32'(NUM_ENTRIES) + 32'(r_cnt);
    assign load_full = 32'(r_hart) * 32'(NUM_ENTRIES) + 32'(r_entry_index);
    assign walk_slot = walk_full[SLOT_W-1:0];
    assign load_slot = load_full[SLOT_W-1:0];
    assign prev_slot = load_slot - SLOT_W'(1);
    assign rd_addr   = i_cmd.rd_prev ? prev_slot : walk_slot;
    assign issue     = i_cmd.walk && !r_issued_all;
    assign ld_mode   = r_cfg_byte[MODE_MSB:MODE_LSB];

    // Item capture on acceptance.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_opcode       <= i_opcode;
            r_hart         <= i_hart;
            r_entry_index  <= i_entry_index;
            r_cfg_byte     <= i_cfg_byte;
            r_addr_word    <= i_addr_word;
            r_region_start <= i_region_start;
            r_region_end   <= {1'b0, i_region_start} + {1'b0, i_region_length};
        end
    end

    // Status for the controller.
    always_comb begin
        o_status.opcode   = r_opcode;
        o_status.hart_ok  = (32'(r_hart) < 32'(NUM_HARTS));
        o_status.load_ok  = o_status.hart_ok && (32'(r_entry_index) < 32'(NUM_ENTRIES));
        o_status.tor_prev = (ld_mode == MODE_TOR) && (r_entry_index != 4'd0);
        o_status.hit      = r_live && match;
        o_status.walk_end = r_issued_all && !r_live;
        o_status.out_free = !r_out_valid || !i_out_stall;
    end

    // Read port of the entry memories; an entry never written reads as zero.
    always_ff @(posedge i_clk) begin
        r_rd_mode  <= mode_mem[rd_addr];
        r_rd_data  <= data_mem[rd_addr];
        r_rd_valid <= r_slot_valid[rd_addr];
    end

    assign prev_mode  = r_rd_valid ? r_rd_mode : MODE_OFF;
    assign prev_entry = r_rd_valid ? r_rd_data : '0;
    assign prev_end   = {3'b000, prev_entry.base} + {1'b0, prev_entry.size};

    // Base of a range entry: end of the previous entry, saturated, or zero for entry 0.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_base <= '0;
        end else if (i_cmd.sum_base) begin
            if (prev_end[END_W-1:BASE_W] != '0) begin
                r_base <= '1;
            end else begin
                r_base <= prev_end[BASE_W-1:0];
            end
        end
    end

    // Decode of the loaded entry for each mode.
    assign top      = {r_addr_word, 2'b00};
    assign tor_diff = {1'b0, top} - {1'b0, r_base};
    assign word_inc = r_addr_word + ADDR_W'(1);
    assign low_zero = ~r_addr_word & word_inc;

    always_comb begin
        wr_entry.read_write = r_cfg_byte[1:0];
        wr_entry.base       = top;
        wr_entry.size       = NA4_SIZE;
        data_we             = 1'b1;
        case (ld_mode)
            MODE_TOR: begin
                wr_entry.base = r_base;
                wr_entry.size = tor_diff[REG_W-1] ? '0 : SIZE_W'(tor_diff[BASE_W-1:0]);
            end
            MODE_NA4: begin
                wr_entry.base = top;
                wr_entry.size = NA4_SIZE;
            end
            MODE_NAPOT: begin
                wr_entry.base = {r_addr_word & word_inc, 2'b00};
                if (low_zero == '0) begin
                    wr_entry.size = {1'b1, {(SIZE_W-1){1'b0}}};
                end else begin
                    wr_entry.size = {1'b0, low_zero, 3'b000};
                end
            end
            default: begin
                // Mode off keeps the old fields; a fresh slot gets its reset value.
                wr_entry = '0;
                data_we  = !r_slot_valid[load_slot];
            end
        endcase
    end

    // Write port of the entry memories.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            mode_mem[load_slot] <= ld_mode;
            if (data_we) begin
                data_mem[load_slot] <= wr_entry;
            end
        end
    end

    // Written flags, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
        end else if (i_cmd.write_entry) begin
            r_slot_valid[load_slot] <= 1'b1;
        end
    end

    // Walk counter: one entry read issued per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_issued_all <= 1'b0;
            r_live       <= 1'b0;
        end else if (i_cmd.accept) begin
            r_cnt        <= '0;
            r_issued_all <= 1'b0;
            r_live       <= 1'b0;
        end else begin
            r_live <= issue;
            if (issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_ENTRIES - 1)) begin
                    r_issued_all <= 1'b1;
                end
            end
        end
    end

    // Containment of the region in the entry just read.
    assign match = (prev_mode != MODE_OFF)
                && (prev_entry.base <= r_region_start)
                && (prev_end >= END_W'(r_region_end));
    assign hit_bit = (r_opcode == OP_WRITE) ? prev_entry.read_write[1]
                                            : prev_entry.read_write[0];

    // Result of the current item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_result) begin
            case (i_cmd.result_sel)
                RES_HIT:  r_result <= hit_bit;
                RES_MISS: r_result <= (r_opcode == OP_WRITE);
                default:  r_result <= 1'b0;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_allowed <= r_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_allowed   = r_allowed;

endmodule

// ----- sv/pmp_region_permission_check.sv -----
// Top level of the physical memory protection region checker.
// The input channel carries one item per beat: a load writes one protection entry of a hart,
// a read or write check asks whether a byte region lies in that hart's first active entry
// that contains it and returns the entry's R or W bit (no entry: read 0, write 1).
// The output channel returns exactly one beat per item with the allowed bit (0 for loads).
// Both channels use valid and stall; a beat moves when valid is high and stall is low.
// One item is worked on at a time. A load with a valid hart and entry index is written
// after decode; a range entry that needs the previous entry first reads it and sums its end.
// A check walks the hart's entries through the single read port of the entry memory, one
// entry per cycle, and an early match ends the walk before the last entry is read.
// The result waits in an output register, so the next item is accepted while it is stalled;
// a stalled output holds its beat, and a second finished result waits inside until it drains.
// Synchronous reset empties the output, returns the controller to idle and marks every entry
// as never written, which reads as off with zero base, size and permissions. No clearing pass
// is needed, so items are accepted as soon as reset is released.
module pmp_region_permission_check
    import pmp_pkg::*;
#(
    parameter int NUM_HARTS   = DEF_NUM_HARTS,
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_opcode,
    input  logic [1:0]        i_hart,
    input  logic [3:0]        i_entry_index,
    input  logic [7:0]        i_cfg_byte,
    input  logic [ADDR_W-1:0] i_addr_word,
    input  logic [BASE_W-1:0] i_region_start,
    input  logic [BASE_W-1:0] i_region_length,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_allowed
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequencer.
    pmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Entry storage and arithmetic.
    pmp_datapath #(
        .NUM_HARTS   (NUM_HARTS),
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_hart          (i_hart),
        .i_entry_index   (i_entry_index),
        .i_cfg_byte      (i_cfg_byte),
        .i_addr_word     (i_addr_word),
        .i_region_start  (i_region_start),
        .i_region_length (i_region_length),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_allowed       (o_allowed)
    );

endmodule

// ----- tb/pmp_region_permission_check_tb.sv -----
// Self-checking testbench for the per-hart protection entry table and its region checks.
`timescale 1ns / 1ps

module pmp_region_permission_check_tb;
    import pmp_pkg::*;

    localparam int NUM_HARTS   = DEF_NUM_HARTS;
    localparam int NUM_ENTRIES = DEF_NUM_ENTRIES;
    localparam int SLOTS       = NUM_HARTS * NUM_ENTRIES;

    // The fourth opcode does nothing and answers zero.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [63:0] BASE_MAX = (64'd1 << BASE_W) - 64'd1;
    localparam logic [63:0] SIZE_MAX = (64'd1 << SIZE_W) - 64'd1;
    localparam logic [BASE_W-1:0] BASE_ONES = {BASE_W{1'b1}};
    localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

    localparam int RANDOM_BLOCKS   = 10;
    localparam int BLOCK_ITEMS     = 125;
    localparam int LONG_HOLD       = 300;
    localparam int WATCHDOG_CYCLES = 4000;

    typedef struct {
        logic [1:0]        opcode;
        logic [1:0]        hart;
        logic [3:0]        idx;
        logic [7:0]        cfg;
        logic [ADDR_W-1:0] addr;
        logic [BASE_W-1:0] start;
        logic [BASE_W-1:0] len;
    } t_pmp_item;

    typedef struct {
        t_pmp_item item;
        bit        has_want;
        bit        want;
    } t_directed_row;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_opcode        = OP_LOAD;
    logic [1:0]        i_hart          = '0;
    logic [3:0]        i_entry_index   = '0;
    logic [7:0]        i_cfg_byte      = '0;
    logic [ADDR_W-1:0] i_addr_word     = '0;
    logic [BASE_W-1:0] i_region_start  = '0;
    logic [BASE_W-1:0] i_region_length = '0;
    logic              o_out_valid;
    logic              i_out_stall     = 1'b0;
    logic              o_allowed;

    // Expected answer typed into the directed rows, carried alongside the beat.
    logic row_has_want = 1'b0;
    logic row_want     = 1'b0;

    // Idling controls shared by the sender, the receiver and the sequence.
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    bit              allowed_q[$];
    t_directed_row   directed_rows[$];
    int              mismatches  = 0;
    int              idle_cycles = 0;

    // Mirror of the entry table, one slot per hart and entry.
    bit [BASE_W-1:0] slot_base [SLOTS];
    bit [SIZE_W-1:0] slot_size [SLOTS];
    bit [1:0]        slot_mode [SLOTS];
    bit [1:0]        slot_rw   [SLOTS];

    pmp_region_permission_check #(
        .NUM_HARTS  (NUM_HARTS),
        .NUM_ENTRIES(NUM_ENTRIES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_hart         (i_hart),
        .i_entry_index  (i_entry_index),
        .i_cfg_byte     (i_cfg_byte),
        .i_addr_word    (i_addr_word),
        .i_region_start (i_region_start),
        .i_region_length(i_region_length),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_allowed      (o_allowed)
    );

    always #5 i_clk = ~i_clk;

    // Applies one item to the mirrored table and returns its allowed bit.
    function automatic bit predict_allowed(input t_pmp_item it);
        int        slot;
        bit [1:0]  mode;
        bit [63:0] word;
        bit [63:0] prev_end;
        bit [63:0] top;
        bit [63:0] ones;
        bit [63:0] region_end;
        bit [63:0] entry_end;
        int        n;
        bit        is_write;
        bit        found;
        bit        result;
        result = 1'b0;
        case (it.opcode)
            OP_LOAD: begin
                slot = int'(it.hart) * NUM_ENTRIES + int'(it.idx);
                mode = it.cfg[MODE_MSB:MODE_LSB];
                slot_mode[slot] = mode;
                // An entry switched off keeps its base, size and permissions.
                if (mode != MODE_OFF) begin
                    slot_rw[slot] = it.cfg[1:0];
                    word = 64'(it.addr);
                    if (mode == MODE_TOR) begin
                        prev_end = 64'd0;
                        if (it.idx != 4'd0) begin
                            prev_end = 64'(slot_base[slot-1]) + 64'(slot_size[slot-1]);
                            if (prev_end > BASE_MAX) begin
                                prev_end = BASE_MAX;
                            end
                        end
                        top = (word << 2) & BASE_MAX;
                        slot_base[slot] = prev_end[BASE_W-1:0];
                        slot_size[slot] = (top >= prev_end) ? SIZE_W'(top - prev_end) : '0;
                    end else if (mode == MODE_NA4) begin
                        slot_base[slot] = BASE_W'((word << 2) & BASE_MAX);
                        slot_size[slot] = NA4_SIZE;
                    end else begin
                        n = 0;
                        while (n < ADDR_W && word[n]) begin
                            n++;
                        end
                        ones = (64'd1 << n) - 64'd1;
                        slot_base[slot] = BASE_W'(((word & ~ones) << 2) & BASE_MAX);
                        slot_size[slot] = SIZE_W'((64'd1 << (n + 3)) & SIZE_MAX);
                    end
                end
            end
            OP_READ, OP_WRITE: begin
                // First active entry holding the whole region decides; a miss
                // refuses reads and allows writes.
                is_write = (it.opcode == OP_WRITE);
                result = is_write;
                found = 1'b0;
                region_end = 64'(it.start) + 64'(it.len);
                for (int i = 0; i < NUM_ENTRIES; i++) begin
                    slot = int'(it.hart) * NUM_ENTRIES + i;
                    if (!found && slot_mode[slot] != MODE_OFF) begin
                        entry_end = 64'(slot_base[slot]) + 64'(slot_size[slot]);
                        if (slot_base[slot] <= it.start && entry_end >= region_end) begin
                            result = slot_rw[slot][is_write];
                            found = 1'b1;
                        end
                    end
                end
            end
            default: result = 1'b0;
        endcase
        return result;
    endfunction

    function automatic logic [7:0] cfg_of(input logic [1:0] mode, input logic [1:0] rw);
        return {3'b000, mode, 1'b0, rw};
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [1:0] hart,
                                    input logic [3:0] idx, input logic [7:0] cfg,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [BASE_W-1:0] start,
                                    input logic [BASE_W-1:0] len,
                                    input bit has_want, input bit want);
        t_directed_row row;
        row.item.opcode = op;
        row.item.hart   = hart;
        row.item.idx    = idx;
        row.item.cfg    = cfg;
        row.item.addr   = addr;
        row.item.start  = start;
        row.item.len    = len;
        row.has_want    = has_want;
        row.want        = want;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Mostly loads and checks in a small address window so that entries and
    // regions meet; the rest is full-width noise.
    function automatic t_pmp_item make_random_item();
        t_pmp_item it;
        int        pick;
        int        kind;
        int        n;
        int        slot;
        bit [63:0] off;
        bit [63:0] len;
        it.hart   = 2'($urandom_range(0, NUM_HARTS - 1));
        it.idx    = 4'($urandom_range(0, NUM_ENTRIES - 1));
        it.cfg    = 8'($urandom_range(0, 255));
        it.addr   = ADDR_W'({$urandom, $urandom});
        it.start  = BASE_W'({$urandom, $urandom});
        it.len    = BASE_W'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 9);
        if (pick < 35) begin
            it.opcode = OP_LOAD;
            if (kind < 6) begin
                it.addr = ADDR_W'($urandom_range(0, 1023));
            end else if (kind < 8) begin
                n = $urandom_range(0, 12);
                it.addr = ADDR_W'((64'($urandom_range(0, 63)) << (n + 1))
                                  | ((64'd1 << n) - 64'd1));
            end else if (kind == 8) begin
                it.addr = ADDR_ONES - ADDR_W'($urandom_range(0, 7));
            end
        end else if (pick < 97) begin
            it.opcode = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
            if (kind < 6) begin
                // Region placed on a stored entry, near its edges.
                slot = int'(it.hart) * NUM_ENTRIES + $urandom_range(0, NUM_ENTRIES - 1);
                off = 64'($urandom_range(0, 7));
                len = (64'(slot_size[slot]) > off) ? 64'(slot_size[slot]) - off : 64'd0;
                case ($urandom_range(0, 3))
                    0: len = len + 64'd1;
                    1: len = len - 64'd1;
                    2: len = len >> $urandom_range(1, 4);
                    default: ;
                endcase
                it.start = slot_base[slot] + BASE_W'(off);
                it.len   = BASE_W'(len);
            end else if (kind < 8) begin
                it.start = BASE_W'($urandom_range(0, 4095));
                it.len   = BASE_W'($urandom_range(0, 256));
            end
        end else begin
            it.opcode = OP_UNUSED;
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input t_pmp_item it, input bit has_want, input bit want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode        <= it.opcode;
        i_hart          <= it.hart;
        i_entry_index   <= it.idx;
        i_cfg_byte      <= it.cfg;
        i_addr_word     <= it.addr;
        i_region_start  <= it.start;
        i_region_length <= it.len;
        row_has_want    <= has_want;
        row_want        <= want;
        i_in_valid      <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Stops offering beats until every expected answer has come back.
    task automatic drain_answers();
        i_in_valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (allowed_q.size() != 0);
    endtask

    // Both channels are watched at the rising edge.
    always @(posedge i_clk) begin : beat_monitor
        t_pmp_item seen;
        bit        predicted;
        bit        want;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (i_in_valid && !o_in_stall) begin
                seen.opcode = i_opcode;
                seen.hart   = i_hart;
                seen.idx    = i_entry_index;
                seen.cfg    = i_cfg_byte;
                seen.addr   = i_addr_word;
                seen.start  = i_region_start;
                seen.len    = i_region_length;
                predicted = predict_allowed(seen);
                allowed_q.push_back(row_has_want ? row_want : predicted);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (allowed_q.size() == 0) begin
                    $error("allowed: beat %0d with no item waiting", o_allowed);
                    mismatches++;
                end else begin
                    want = allowed_q.pop_front();
                    if (o_allowed !== want) begin
                        $error("allowed: expected %0d, got %0d", want, o_allowed);
                        mismatches++;
                    end
                end
                moved = 1'b1;
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // Output stall: random runs, a long hold on request, or none at all.
    initial begin : out_stall_driver
        int run;
        bit stalled;
        run = 0;
        stalled = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                run = 0;
            end else if (rx_quiet) begin
                i_out_stall <= 1'b0;
                run = 0;
            end else begin
                if (run == 0) begin
                    stalled = ($urandom_range(0, 2) == 0);
                    if (!stalled) begin
                        run = $urandom_range(1, 12);
                    end else if ($urandom_range(0, 9) == 0) begin
                        run = $urandom_range(10, 40);
                    end else begin
                        run = $urandom_range(1, 3);
                    end
                end
                run--;
                i_out_stall <= stalled;
            end
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
        end
        $display("pmp_region_permission_check regression: fail");
        $finish;
    end

    initial begin : stimulus
        t_directed_row row;
        t_pmp_item     it;
        int            style;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table, extremes, every opcode and each decoding corner.
        add_row(OP_READ,   2'd0, 4'd0,  8'h00, '0, '0, '0, 1'b1, 1'b0);
        add_row(OP_WRITE,  2'd3, 4'd15, 8'hFF, ADDR_ONES, BASE_ONES, BASE_ONES, 1'b1, 1'b1);
        add_row(OP_UNUSED, 2'd2, 4'd9,  8'hFF, ADDR_ONES, BASE_ONES, BASE_ONES, 1'b1, 1'b0);
        // Widest naturally aligned entry, then a range entry past the address space.
        add_row(OP_LOAD,   2'd0, 4'd0, cfg_of(MODE_NAPOT, 2'b11), ADDR_ONES, '0, '0,
                1'b1, 1'b0);
        add_row(OP_READ,   2'd0, 4'd0, 8'h00, '0, '0, BASE_ONES, 1'b0, 1'b0);
        add_row(OP_LOAD,   2'd0, 4'd1, cfg_of(MODE_TOR, 2'b01), '0, '0, '0, 1'b1, 1'b0);
        // Switching entry 0 off must leave its base and size for the next range entry.
        add_row(OP_LOAD,   2'd0, 4'd0, {3'b111, MODE_OFF, 3'b111}, 54'h2A, '0, '0,
                1'b1, 1'b0);
        add_row(OP_LOAD,   2'd0, 4'd1, cfg_of(MODE_TOR, 2'b01), 54'h10, '0, '0, 1'b1, 1'b0);
        add_row(OP_READ,   2'd0, 4'd0, 8'h00, '0, BASE_ONES, '0, 1'b0, 1'b0);
        add_row(OP_WRITE,  2'd0, 4'd0, 8'h00, '0, BASE_ONES, '0, 1'b0, 1'b0);
        // Range from zero, the inclusive end, one byte past it, and a top below the base.
        add_row(OP_LOAD,   2'd1, 4'd0, cfg_of(MODE_TOR, 2'b11), 54'h100, '0, '0, 1'b1, 1'b0);
        add_row(OP_READ,   2'd1, 4'd0, 8'h00, '0, '0, 56'h400, 1'b0, 1'b0);
        add_row(OP_READ,   2'd1, 4'd0, 8'h00, '0, '0, 56'h401, 1'b0, 1'b0);
        add_row(OP_LOAD,   2'd1, 4'd1, cfg_of(MODE_TOR, 2'b10), 54'h80, '0, '0, 1'b1, 1'b0);
        add_row(OP_WRITE,  2'd1, 4'd0, 8'h00, '0, 56'h400, '0, 1'b0, 1'b0);
        // Four-byte entry at the very top of the address space.
        add_row(OP_LOAD,   2'd2, 4'd15, cfg_of(MODE_NA4, 2'b01), ADDR_ONES, '0, '0,
                1'b1, 1'b0);
        add_row(OP_READ,   2'd2, 4'd0, 8'h00, '0, BASE_ONES - 56'd3, 56'd4, 1'b0, 1'b0);
        add_row(OP_WRITE,  2'd2, 4'd0, 8'h00, '0, BASE_ONES - 56'd3, 56'd4, 1'b0, 1'b0);
        // Smallest naturally aligned entry, and one with ignored bits set in its byte.
        add_row(OP_LOAD,   2'd2, 4'd3, cfg_of(MODE_NAPOT, 2'b10), '0, '0, '0, 1'b1, 1'b0);
        add_row(OP_WRITE,  2'd2, 4'd0, 8'h00, '0, '0, 56'd8, 1'b0, 1'b0);
        add_row(OP_LOAD,   2'd3, 4'd7, {3'b111, MODE_NAPOT, 3'b111}, 54'hF, '0, '0,
                1'b1, 1'b0);
        add_row(OP_READ,   2'd3, 4'd0, 8'h00, '0, 56'h40, 56'h40, 1'b0, 1'b0);
        add_row(OP_WRITE,  2'd3, 4'd0, 8'h00, '0, 56'h41, 56'h40, 1'b0, 1'b0);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            send_beat(row.item, row.has_want, row.want);
        end
        drain_answers();

        // Random blocks; the idling pattern cycles through four styles by block number.
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            style = blk % 4;
            tx_quiet = (style == 1 || style == 2);
            rx_quiet = (style == 1 || style == 3);
            if (blk == 4) begin
                // Long output hold while beats keep coming, so the block backs up.
                rx_quiet = 1'b0;
                tx_quiet = 1'b1;
                rx_hold_req = 1'b1;
            end
            if (blk == 7) begin
                drain_answers();
            end
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                it = make_random_item();
                send_beat(it, 1'b0, 1'b0);
            end
        end

        drain_answers();
        repeat (NUM_ENTRIES + 8) @(posedge i_clk);
        if (mismatches == 0 && allowed_q.size() == 0) begin
            $display("pmp_region_permission_check regression: pass");
        end else begin
            $display("pmp_region_permission_check regression: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/pmp_pkg.sv
sv/pmp_ctrl.sv
sv/pmp_datapath.sv
sv/pmp_region_permission_check.sv
tb/pmp_region_permission_check_tb.sv
